[design/node_heartbeat_liveness_monitor_assert.svh]
// Assertion macros for the heartbeat liveness monitor.
`ifndef NODE_HEARTBEAT_LIVENESS_MONITOR_ASSERT_SVH
`define NODE_HEARTBEAT_LIVENESS_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define HBLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HBLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/hblm_pkg.sv]
`timescale 1ns / 1ps

package hblm_pkg;

    // Op codes of the input item (5 to 7 behave as a status query)
    localparam logic [2:0] OP_HEARTBEAT = 3'd0;
    localparam logic [2:0] OP_BATCH_END = 3'd1;
    localparam logic [2:0] OP_ITEM_RCVD = 3'd2;
    localparam logic [2:0] OP_TICK      = 3'd3;
    localparam logic [2:0] OP_QUERY     = 3'd4;

    // Commands
    localparam logic [1:0] CMD_NONE      = 2'd0;
    localparam logic [1:0] CMD_CONFIGURE = 2'd1;
    localparam logic [1:0] CMD_PING      = 2'd2;

    // Node status codes
    localparam logic [1:0] STS_OFFLINE  = 2'd0;
    localparam logic [1:0] STS_ONLINE   = 2'd1;
    localparam logic [1:0] STS_AWAITING = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_RETRY_LIMIT    = 3'd0;
    localparam logic [2:0] CFG_RETRY_INTERVAL = 3'd1;
    localparam logic [2:0] CFG_HB_TIMEOUT     = 3'd2;
    localparam logic [2:0] CFG_SECOND_PING    = 3'd3;
    localparam logic [2:0] CFG_OFFLINE_AGE    = 3'd4;

    localparam int CFG_DATA_W = 20;

    // Uptime below this counts as a fresh boot
    localparam logic [31:0] BOOT_UPTIME_LIMIT = 32'd5;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  node;
        logic [31:0] now_ms;
        logic [31:0] node_uptime_s;
        logic [31:0] batch_expected;
        logic [31:0] batch_received;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  command_node;
        logic [1:0]  node_status;
        logic [31:0] mismatch_count;
        logic [31:0] received_count;
        logic [31:0] expected_count;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        online;
        logic        configured;
        logic [31:0] last_uptime;
        logic [31:0] last_heartbeat_ms;
        logic [1:0]  ping_stage;
        logic [7:0]  config_retries;
        logic [31:0] last_config_sent_ms;
        logic [31:0] mismatches;
        logic [31:0] received;
        logic [31:0] expected;
    } t_node_rec;

    // Request to the shared subtract/compare unit: hit = (a - b) >(=) thr
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] thr;
        logic        gt_mode;
    } t_cmp_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_ACT,
        ST_FLUSH
    } t_state;

    function automatic logic [1:0] node_status(input t_node_rec rec);
        if (!rec.online) begin
            return STS_OFFLINE;
        end
        return (rec.ping_stage != 2'd0) ? STS_AWAITING : STS_ONLINE;
    endfunction

endpackage

[design/hblm_cmp_unit.sv]
`timescale 1ns / 1ps

// Shared wrap-around age compare: registers (a - b) > thr or (a - b) >= thr.
module hblm_cmp_unit (
    input  logic              i_clk,
    input  logic              i_load,
    input  hblm_pkg::t_cmp_req i_req,
    output logic              o_hit
);

    logic [31:0] diff;
    logic        ge;
    logic        eq;
    logic        r_hit;

    assign diff = i_req.a - i_req.b;
    assign ge   = (diff >= i_req.thr);
    assign eq   = (diff == i_req.thr);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hit <= i_req.gt_mode ? (ge && !eq) : ge;
        end
    end

    assign o_hit = r_hit;

endmodule

[design/hblm_node_store.sv]
`timescale 1ns / 1ps

// Per-node records, one read and one write port on the same index space.
module hblm_node_store #(
    parameter int NODE_COUNT = 4,
    parameter int IDX_W      = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [IDX_W-1:0]     i_rd_idx,
    output hblm_pkg::t_node_rec  o_rd_rec,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_idx,
    input  hblm_pkg::t_node_rec  i_wr_rec
);

    hblm_pkg::t_node_rec r_recs [NODE_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NODE_COUNT; k++) begin
                r_recs[k] <= '0;
            end
        end else if (i_wr_en) begin
            r_recs[i_wr_idx] <= i_wr_rec;
        end
    end

    assign o_rd_rec = r_recs[i_rd_idx];

endmodule

[design/node_heartbeat_liveness_monitor.sv]
`timescale 1ns / 1ps

// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+-------------------------------
// in      | input     | i_in_valid / o_in_stall    | i_in_item  (hblm_pkg::t_in_item)
// out     | output    | o_out_valid / i_out_stall  | o_out_item (hblm_pkg::t_out_item)
// cfg     | input     | i_cfg_wr_en, no handshake  | i_cfg_index, i_cfg_wr_data
//
// Heartbeat, batch end, item received and query pass through accept, compare and update steps.
// A tick runs one compare and one update step per node, all
// sharing a single 32-bit subtract/compare unit, then a closing flush step.
// Synchronous active-low reset clears all node records and loads register defaults.
// A stalled output holds an update or flush step that must push a result until the output register frees up.

module node_heartbeat_liveness_monitor #(
    parameter int NODE_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input items
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hblm_pkg::t_in_item  i_in_item,
    // results
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hblm_pkg::t_out_item o_out_item,
    // configuration writes
    input  logic                i_cfg_wr_en,
    input  logic [2:0]          i_cfg_index,
    input  logic [hblm_pkg::CFG_DATA_W-1:0] i_cfg_wr_data
);

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

    // ---------------------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------------------
    logic [7:0]  r_retry_limit;
    logic [19:0] r_retry_interval;
    logic [19:0] r_hb_timeout;
    logic [19:0] r_second_ping;
    logic [19:0] r_offline_age;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit    <= 8'd3;
            r_retry_interval <= 20'd2000;
            r_hb_timeout     <= 20'd5000;
            r_second_ping    <= 20'd8000;
            r_offline_age    <= 20'd12000;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                hblm_pkg::CFG_RETRY_LIMIT:    r_retry_limit    <= i_cfg_wr_data[7:0];
                hblm_pkg::CFG_RETRY_INTERVAL: r_retry_interval <= i_cfg_wr_data;
                hblm_pkg::CFG_HB_TIMEOUT:     r_hb_timeout     <= i_cfg_wr_data;
                hblm_pkg::CFG_SECOND_PING:    r_second_ping    <= i_cfg_wr_data;
                hblm_pkg::CFG_OFFLINE_AGE:    r_offline_age    <= i_cfg_wr_data;
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // Sequencer state and item registers
    // ---------------------------------------------------------------------------------
    hblm_pkg::t_state    r_state, n_state;
    hblm_pkg::t_in_item  r_item;
    logic [IDX_W-1:0]    r_idx;          // node walked by a tick
    hblm_pkg::t_out_item r_pend;         // last tick result, held until we know if it is final
    logic                r_pend_valid;
    hblm_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic                in_xfer;
    logic                is_tick;
    logic                node_ok;
    logic [IDX_W-1:0]    sel_idx;
    hblm_pkg::t_node_rec rd_rec;
    hblm_pkg::t_node_rec n_rec;
    logic                cfg_path;       // tick: node is owed a configure resend
    hblm_pkg::t_cmp_req  cmp_req;
    logic                cmp_load;
    logic                cmp_hit;
    logic [1:0]          act_cmd;
    logic                act_emit;
    hblm_pkg::t_out_item act_item;
    logic                can_push;
    logic                act_go;
    logic                push;
    hblm_pkg::t_out_item push_item;
    logic                wr_en;
    logic                pend_load;
    logic                pend_clear;
    logic                idx_step;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign can_push = !r_out_valid || !i_out_stall;
    assign is_tick  = (r_item.op == hblm_pkg::OP_TICK);
    assign node_ok  = ({1'b0, r_item.node} < 5'(NODE_COUNT));
    assign sel_idx  = is_tick ? r_idx : r_item.node[IDX_W-1:0];

    hblm_node_store #(
        .NODE_COUNT (NODE_COUNT),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (sel_idx),
        .o_rd_rec (rd_rec),
        .i_wr_en  (wr_en),
        .i_wr_idx (sel_idx),
        .i_wr_rec (n_rec)
    );

    // ---------------------------------------------------------------------------------
    // Compare operands. A tick asks one question per node: the resend interval for an
    // unconfigured node, otherwise the heartbeat age against the threshold of its ping
    // stage. A heartbeat asks whether the stored uptime exceeds the new one plus one.
    // ---------------------------------------------------------------------------------
    assign cfg_path = !rd_rec.configured && (rd_rec.config_retries < r_retry_limit);

    always_comb begin
        cmp_req = '0;
        if (is_tick) begin
            cmp_req.a = r_item.now_ms;
            if (cfg_path) begin
                cmp_req.b       = rd_rec.last_config_sent_ms;
                cmp_req.thr     = {12'd0, r_retry_interval};
                cmp_req.gt_mode = 1'b0;
            end else begin
                cmp_req.b       = rd_rec.last_heartbeat_ms;
                cmp_req.gt_mode = 1'b1;
                case (rd_rec.ping_stage)
                    2'd0:    cmp_req.thr = {12'd0, r_hb_timeout};
                    2'd1:    cmp_req.thr = {12'd0, r_second_ping};
                    2'd2:    cmp_req.thr = {12'd0, r_offline_age};
                    default: cmp_req.thr = '1;  // stage never reached: no hit
                endcase
            end
        end else begin
            cmp_req.a       = rd_rec.last_uptime;
            cmp_req.b       = '0;
            cmp_req.thr     = r_item.node_uptime_s + 32'd1;
            cmp_req.gt_mode = 1'b1;
        end
    end

    hblm_cmp_unit u_cmp (
        .i_clk  (i_clk),
        .i_load (cmp_load),
        .i_req  (cmp_req),
        .o_hit  (cmp_hit)
    );

    // ---------------------------------------------------------------------------------
    // Record update and result for the current node
    // ---------------------------------------------------------------------------------
    always_comb begin
        logic fresh;
        fresh    = 1'b0;
        n_rec    = rd_rec;
        act_cmd  = hblm_pkg::CMD_NONE;
        if (is_tick) begin
            if (cfg_path) begin
                if (cmp_hit) begin
                    n_rec.config_retries      = rd_rec.config_retries + 8'd1;
                    n_rec.last_config_sent_ms = r_item.now_ms;
                    act_cmd                   = hblm_pkg::CMD_CONFIGURE;
                end
            end else if (rd_rec.online && cmp_hit) begin
                if (rd_rec.ping_stage == 2'd2) begin
                    // silent past the last ping: drop to offline
                    n_rec.online         = 1'b0;
                    n_rec.configured     = 1'b0;
                    n_rec.config_retries = 8'd0;
                end else begin
                    n_rec.ping_stage = rd_rec.ping_stage + 2'd1;
                    act_cmd          = hblm_pkg::CMD_PING;
                end
            end
        end else if (node_ok) begin
            // out-of-range node: record untouched, no command
            case (r_item.op)
                hblm_pkg::OP_HEARTBEAT: begin
                    fresh = (r_item.node_uptime_s < hblm_pkg::BOOT_UPTIME_LIMIT) &&
                            (cmp_hit || !rd_rec.online);
                    n_rec.online            = 1'b1;
                    n_rec.last_uptime       = r_item.node_uptime_s;
                    n_rec.last_heartbeat_ms = r_item.now_ms;
                    n_rec.ping_stage        = 2'd0;
                    if (fresh || !rd_rec.configured) begin
                        act_cmd                   = hblm_pkg::CMD_CONFIGURE;
                        n_rec.configured          = 1'b1;
                        n_rec.config_retries      = 8'd0;
                        n_rec.last_config_sent_ms = r_item.now_ms;
                    end
                end
                hblm_pkg::OP_BATCH_END: begin
                    n_rec.expected = r_item.batch_expected;
                    if (r_item.batch_received != r_item.batch_expected) begin
                        n_rec.mismatches = rd_rec.mismatches + 32'd1;
                    end
                    n_rec.received = '0;
                end
                hblm_pkg::OP_ITEM_RCVD: begin
                    n_rec.received = rd_rec.received + 32'd1;
                end
                default: ;  // query and unused ops leave the record alone
            endcase
        end

        act_emit = (act_cmd != hblm_pkg::CMD_NONE);

        act_item         = '0;
        act_item.command = act_cmd;
        act_item.last    = !is_tick;
        if (is_tick) begin
            act_item.command_node = 4'(r_idx);
        end else begin
            act_item.command_node = r_item.node;
        end
        if (is_tick || node_ok) begin
            act_item.node_status    = hblm_pkg::node_status(n_rec);
            act_item.mismatch_count = n_rec.mismatches;
            act_item.received_count = n_rec.received;
            act_item.expected_count = n_rec.expected;
        end
    end

    // ---------------------------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hblm_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = hblm_pkg::ST_CALC;
                end
            end
            hblm_pkg::ST_CALC: begin
                n_state = hblm_pkg::ST_ACT;
            end
            hblm_pkg::ST_ACT: begin
                if (act_go) begin
                    if (!is_tick) begin
                        n_state = hblm_pkg::ST_IDLE;
                    end else if (r_idx == LAST_IDX) begin
                        n_state = hblm_pkg::ST_FLUSH;
                    end else begin
                        n_state = hblm_pkg::ST_CALC;
                    end
                end
            end
            hblm_pkg::ST_FLUSH: begin
                if (can_push) begin
                    n_state = hblm_pkg::ST_IDLE;
                end
            end
            default: n_state = hblm_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------------------
    // Sequencer: outputs
    // A tick result goes to the pending register first; it moves on (last = 0) when a
    // later node emits, or with last = 1 in the flush step. A tick with nothing to send
    // flushes an all-zero result.
    // ---------------------------------------------------------------------------------
    always_comb begin
        o_in_stall = 1'b1;
        cmp_load   = 1'b0;
        act_go     = 1'b0;
        push       = 1'b0;
        push_item  = act_item;
        wr_en      = 1'b0;
        pend_load  = 1'b0;
        pend_clear = 1'b0;
        idx_step   = 1'b0;
        unique case (r_state)
            hblm_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            hblm_pkg::ST_CALC: begin
                cmp_load = 1'b1;
            end
            hblm_pkg::ST_ACT: begin
                if (is_tick) begin
                    act_go    = !(act_emit && r_pend_valid) || can_push;
                    push      = act_go && act_emit && r_pend_valid;
                    push_item = r_pend;
                    pend_load = act_go && act_emit;
                    wr_en     = act_go;
                    idx_step  = act_go;
                end else begin
                    act_go = can_push;
                    push   = can_push;
                    wr_en  = can_push && node_ok;
                end
            end
            hblm_pkg::ST_FLUSH: begin
                push       = can_push;
                pend_clear = can_push;
                push_item  = r_pend_valid ? r_pend : '0;
                push_item.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hblm_pkg::ST_IDLE;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_idx <= '0;
            end else if (idx_step && (r_idx != LAST_IDX)) begin
                r_idx <= r_idx + 1'b1;
            end
            if (pend_load) begin
                r_pend_valid <= 1'b1;
            end else if (pend_clear) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in_item;
        end
        if (pend_load) begin
            r_pend <= act_item;
        end
        if (push) begin
            r_out <= push_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ---------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------
`include "node_heartbeat_liveness_monitor_assert.svh"

    // a new item is only taken once the previous tick has flushed its pending result
    `HBLM_ASSERT_NOW(a_idle_no_pend, i_clk, i_rst_n, !o_in_stall, !r_pend_valid, "pending result while idle")
    // a transfer in closes the input for at least the next cycle
    `HBLM_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, in_xfer, o_in_stall, "input open after transfer")
    // only tick results can be non-final, and those always carry a command
    `HBLM_ASSERT_NOW(a_nonlast_cmd, i_clk, i_rst_n, o_out_valid && !o_out_item.last, o_out_item.command != hblm_pkg::CMD_NONE, "non-final result without command")
    // the record store is written only during an update step
    `HBLM_ASSERT_NOW(a_wr_in_act, i_clk, i_rst_n, wr_en, r_state == hblm_pkg::ST_ACT, "store write outside update step")

endmodule
